// ----- rtl/tcs_pkg.sv -----
// Shared types, codes and constants of the text case stream block.
package tcs_pkg;

    // Separator set and banner padding limits
    localparam int SEP_SET_SIZE = 4;
    localparam int PAD_BYTES    = 8;
    // Separator slots that the 32-bit register can actually hold
    localparam int SEP_SLOTS    = (SEP_SET_SIZE < 4) ? SEP_SET_SIZE : 4;

    // Default depth of the job queue between front and back
    localparam int TCS_FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Configuration register indexes
    localparam logic [2:0] REG_CASE_MODE   = 3'd0;
    localparam logic [2:0] REG_NL_RESTART  = 3'd1;
    localparam logic [2:0] REG_SEP_CHARS   = 3'd2;
    localparam logic [2:0] REG_SEP_COUNT   = 3'd3;
    localparam logic [2:0] REG_GAP_TEXT    = 3'd4;
    localparam logic [2:0] REG_GAP_LEN     = 3'd5;
    localparam logic [2:0] REG_PAD_TEXT    = 3'd6;
    localparam logic [2:0] REG_PAD_LEN     = 3'd7;

    // Case modes; code 7 is unused and behaves as plain
    typedef enum logic [2:0] {
        MODE_PROPER = 3'd0,
        MODE_CAPS   = 3'd1,
        MODE_BANNER = 3'd2,
        MODE_LOWER  = 3'd3,
        MODE_RANSOM = 3'd4,
        MODE_TITLE  = 3'd5,
        MODE_PLAIN  = 3'd6
    } mode_t;

    // Kind of work queued for the back end
    typedef enum logic {
        JOB_CHAR = 1'b0,
        JOB_GAP  = 1'b1
    } kind_t;

    // One queued request: what to emit and the index of its last byte
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_byte;
        logic [3:0] last_idx;
    } job_t;

    // Configuration register set
    typedef struct packed {
        logic [2:0]  case_mode;
        logic        newline_restarts;
        logic [31:0] sep_chars;
        logic [2:0]  sep_count;
        logic [63:0] gap_text;
        logic [3:0]  gap_len;
        logic [63:0] pad_text;
        logic [3:0]  pad_len;
    } cfg_t;

endpackage

// ----- rtl/tcs_front.sv -----
// Front end: classifies each input byte, tracks positions and queues output work.
module tcs_front
    import tcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job,
    input  logic       full
);

    logic       word_first_reg, word_first_next;
    logic [1:0] word_res_reg, word_res_next;
    logic       sent_first_reg, sent_first_next;
    logic [1:0] sent_res_reg, sent_res_next;

    logic       accept;
    logic       term;
    logic       sep;
    logic       emits;
    logic       is_banner;
    logic [7:0] conv;
    logic [3:0] pad_last;
    logic [3:0] gap_last;

    // Residue mod 3 of a value up to 11
    function automatic logic [1:0] mod3_small(input logic [3:0] x);
        logic [3:0] r;
        begin
            r = x;
            if (r >= 4'd9) begin
                r = r - 4'd9;
            end else if (r >= 4'd6) begin
                r = r - 4'd6;
            end else if (r >= 4'd3) begin
                r = r - 4'd3;
            end
            mod3_small = r[1:0];
        end
    endfunction

    // Byte mod 3: base-4 digits each weigh one mod 3
    function automatic logic [1:0] mod3_byte(input logic [7:0] c);
        logic [3:0] s;
        begin
            s = 4'(c[1:0]) + 4'(c[3:2]) + 4'(c[5:4]) + 4'(c[7:6]);
            mod3_byte = mod3_small(s);
        end
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] x);
        begin
            inc3 = (x inside {2'd2, 2'd3}) ? 2'd0 : x + 2'd1;
        end
    endfunction

    function automatic logic [7:0] to_up(input logic [7:0] c);
        begin
            to_up = (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
        end
    endfunction

    function automatic logic [7:0] to_low(input logic [7:0] c);
        begin
            to_low = (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
        end
    endfunction

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    // Classify: terminal punctuation and separator membership
    always_comb begin
        term = (in_byte inside {CH_DOT, CH_BANG, CH_QUERY}) ||
               (cfg.newline_restarts && in_byte == CH_NEWLINE);
        sep = 1'b0;
        for (int i = 0; i < SEP_SLOTS; i++) begin
            if (4'(i) < {1'b0, cfg.sep_count} && cfg.sep_chars[8*i +: 8] == in_byte &&
                in_byte != CH_NUL) begin
                sep = 1'b1;
            end
        end
    end

    // Convert the letter case according to mode
    always_comb begin
        logic       sent0;
        logic       word0;
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] r;
        logic [3:0] prod;
        logic [3:0] total;
        logic [7:0] o;
        sent0 = !term && sent_first_reg;
        word0 = !term && word_first_reg;
        a     = term ? 2'd0 : inc3(word_res_reg);
        b     = term ? 2'd0 : inc3(sent_res_reg);
        prod  = 4'(a) * 4'(b);
        total = prod + 4'(a) + 4'(b) + 4'(mod3_byte(in_byte)) + 4'd1;
        r     = mod3_small(total);
        case (r)
            2'd0:    o = to_low(in_byte);
            2'd1:    o = to_up(in_byte);
            default: o = in_byte[0] ? to_up(in_byte) : to_low(in_byte);
        endcase
        if (in_byte[7]) begin
            conv = in_byte;
        end else begin
            case (cfg.case_mode)
                MODE_PROPER:              conv = sent0 ? to_up(in_byte) : to_low(in_byte);
                MODE_CAPS, MODE_BANNER:   conv = to_up(in_byte);
                MODE_LOWER:               conv = to_low(in_byte);
                MODE_RANSOM:              conv = sent0 ? to_up(o) : o;
                MODE_TITLE:               conv = word0 ? to_up(in_byte) : to_low(in_byte);
                default:                  conv = in_byte;
            endcase
        end
    end

    // Work out the last byte index of the queued request
    always_comb begin
        is_banner = (cfg.case_mode == MODE_BANNER);
        if (cfg.pad_len == 4'd0) begin
            pad_last = 4'd1;
        end else if (cfg.pad_len > 4'(PAD_BYTES)) begin
            pad_last = 4'(PAD_BYTES);
        end else begin
            pad_last = cfg.pad_len;
        end
        gap_last = (cfg.gap_len > 4'd8) ? 4'd7 : cfg.gap_len - 4'd1;
        emits    = sep ? (cfg.gap_len != 4'd0) : (in_byte != CH_NUL);
        push_job.kind      = sep ? JOB_GAP : JOB_CHAR;
        push_job.char_byte = conv;
        push_job.last_idx  = sep ? gap_last : (is_banner ? pad_last : 4'd0);
    end

    assign push = accept && emits;

    // Advance word and sentence positions
    always_comb begin
        sent_first_next = sent_first_reg;
        sent_res_next   = sent_res_reg;
        if (term) begin
            sent_first_next = 1'b1;
            sent_res_next   = 2'd0;
        end else if (!(sep && sent_first_reg)) begin
            sent_first_next = 1'b0;
            sent_res_next   = inc3(sent_res_reg);
        end
        if (term || sep) begin
            word_first_next = 1'b1;
            word_res_next   = 2'd0;
        end else begin
            word_first_next = 1'b0;
            word_res_next   = inc3(word_res_reg);
        end
    end

    // Hold positions until a byte is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_first_reg <= 1'b1;
            word_res_reg   <= 2'd0;
            sent_first_reg <= 1'b1;
            sent_res_reg   <= 2'd0;
        end else if (accept) begin
            word_first_reg <= word_first_next;
            word_res_reg   <= word_res_next;
            sent_first_reg <= sent_first_next;
            sent_res_reg   <= sent_res_next;
        end
    end

endmodule

// ----- rtl/tcs_queue.sv -----
// Short job queue that decouples the front end from the back end.
module tcs_queue
    import tcs_pkg::*;
#(
    parameter int DEPTH = TCS_FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    // Store requests
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

// ----- rtl/tcs_back.sv -----
// Back end: expands queued requests into output bytes, one per cycle unless m_tready stalls.
module tcs_back
    import tcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  job_t       head_job,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [3:0] idx_reg, idx_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic       head_valid;
    logic       out_free;
    logic       emit;
    logic       is_last;
    logic [7:0] byte_sel;
    logic [2:0] pad_idx;

    assign head_valid = !empty;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit       = out_free && head_valid;
    assign is_last    = (idx_reg == head_job.last_idx);
    assign pop        = emit && is_last;
    assign idx_next   = is_last ? 4'd0 : idx_reg + 4'd1;
    assign pad_idx    = 3'(idx_reg - 4'd1);

    // Pick the byte at the current index of the head request
    always_comb begin
        case (head_job.kind)
            JOB_GAP: byte_sel = cfg.gap_text[{idx_reg[2:0], 3'b000} +: 8];
            JOB_CHAR: begin
                if (idx_reg == 4'd0) begin
                    byte_sel = head_job.char_byte;
                end else if (cfg.pad_len == 4'd0) begin
                    byte_sel = CH_UNDER;
                end else begin
                    byte_sel = cfg.pad_text[{pad_idx, 3'b000} +: 8];
                end
            end
            default: byte_sel = head_job.char_byte;
        endcase
    end

    // Hold control state of the output register and byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 4'd0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
            idx_reg      <= idx_next;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid_reg && m_tlast_reg)
        else $error("request retired without a last byte");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg <= head_job.last_idx)
        else $error("byte index ran past the request");

    a_idx_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 4'd0 |-> head_valid)
        else $error("byte index left over with no request queued");

endmodule

// ----- rtl/text_case_stream.sv -----
// Top level of the text case stream: configuration registers, front, queue and back.
//
//  Channel   Dir  Handshake            Payload
//  s_        in   s_tvalid/s_tready    s_tdata[7:0] = in_byte
//  m_        out  m_tvalid/m_tready    m_tdata[7:0] = out_byte, m_tlast = run_last
//  cfg_      in   cfg_wr_en            cfg_index[2:0], cfg_wdata[63:0]
//
// The front accepts one byte per cycle while the job queue (FIFO_DEPTH entries) has room.
// The back emits one byte per cycle while a request is queued and m_tready does not hold
// the output; an input byte yields 0 to 9 bytes, and the output register sets the rate.
// An accepted byte passes through the queue entry and then the output register to m_tdata.
// Reset is synchronous and active low; it restores defaults and clears the queue.
// A low m_tready holds the output register; the queue then fills and s_tready drops.
module text_case_stream
    import tcs_pkg::*;
#(
    parameter int FIFO_DEPTH = TCS_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t head_job;
    logic empty;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.case_mode        <= MODE_PROPER;
            cfg_reg.newline_restarts <= 1'b0;
            cfg_reg.sep_chars        <= {24'd0, CH_SPACE};
            cfg_reg.sep_count        <= 3'd1;
            cfg_reg.gap_text         <= {56'd0, CH_SPACE};
            cfg_reg.gap_len          <= 4'd1;
            cfg_reg.pad_text         <= {56'd0, CH_SPACE};
            cfg_reg.pad_len          <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CASE_MODE:  cfg_reg.case_mode        <= cfg_wdata[2:0];
                REG_NL_RESTART: cfg_reg.newline_restarts <= cfg_wdata[0];
                REG_SEP_CHARS:  cfg_reg.sep_chars        <= cfg_wdata[31:0];
                REG_SEP_COUNT:  cfg_reg.sep_count        <= cfg_wdata[2:0];
                REG_GAP_TEXT:   cfg_reg.gap_text         <= cfg_wdata;
                REG_GAP_LEN:    cfg_reg.gap_len          <= cfg_wdata[3:0];
                REG_PAD_TEXT:   cfg_reg.pad_text         <= cfg_wdata;
                REG_PAD_LEN:    cfg_reg.pad_len          <= cfg_wdata[3:0];
                default:        cfg_reg.case_mode        <= cfg_reg.case_mode;
            endcase
        end
    end

    tcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    tcs_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    tcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
